FILE: sv/dlpc_pkg.sv
// Shared types and constants for the disk lattice point counter.
// Request/result payloads, controller states and the controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dlpc_pkg;

    localparam logic [1:0] KIND_RAW  = 2'd0;
    localparam logic [1:0] KIND_DISK = 2'd1;
    localparam logic [1:0] KIND_RING = 2'd2;

    localparam int VALUE_W = 24;
    localparam int COUNT_W = 26;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] point_count;
        logic               status;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CHECK,
        ST_SQ_START,
        ST_SQRT,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic calc_n;
        logic fail;
        logic set_outer;
        logic set_inner;
        logic sqrt_start;
        logic walk_init;
        logic walk_step;
        logic keep_first;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic too_large;
        logic sqrt_busy;
        logic walk_done;
        logic need_inner;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: sv/dlpc_isqrt.sv
// Bit-serial floor square root, two radicand bits per cycle.
// Standalone; used by dlpc_datapath.
`timescale 1ns / 1ps
`default_nettype none

module dlpc_isqrt #(
    parameter int W = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [W-1:0]         radicand,
    output logic                      busy,
    output logic [(W+1)/2-1:0]        root
);

    localparam int H  = (W + 1) / 2;
    localparam int SW = 2 * H;

    logic [SW-1:0] rem_reg, rem_next;
    logic [SW-1:0] res_reg, res_next;
    logic [SW-1:0] bit_reg, bit_next;
    logic          run_reg, run_next;
    logic [SW-1:0] trial;

    always_comb
    begin
        trial    = res_reg + bit_reg;
        rem_next = rem_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        run_next = run_reg;
        if (start)
        begin
            rem_next = SW'(radicand);
            res_next = '0;
            bit_next = SW'(1) << (SW - 2);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            // last pair of bits done
            run_next = (bit_reg[1:0] == 2'b00);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign busy = run_reg;
    assign root = res_reg[H-1:0];

endmodule

`default_nettype wire

FILE: sv/dlpc_datapath.sv
// Datapath: request capture, bound check, square root and the i/y walk.
// Depends on dlpc_pkg and dlpc_isqrt.
`timescale 1ns / 1ps
`default_nettype none

module dlpc_datapath #(
    parameter int BOUND_BITS = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dlpc_pkg::req_t     req,
    input  wire dlpc_pkg::ctrl_cmd_t cmd,
    output dlpc_pkg::dp_stat_t      stat,
    output dlpc_pkg::res_t          result
);

    localparam int W   = BOUND_BITS;
    localparam int H   = (W + 1) / 2;
    localparam int IW  = H + 1;
    localparam int CW  = W + 4;
    localparam int OW  = (CW > dlpc_pkg::COUNT_W) ? CW : dlpc_pkg::COUNT_W;
    localparam int NW  = 2 * dlpc_pkg::VALUE_W + 1;
    localparam logic [NW-1:0] BOUND_MAX = (NW'(1) << W) - NW'(1);

    logic [1:0]                  kind_reg, kind_next;
    logic [dlpc_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [NW-1:0]               n_wide_reg, n_wide_next;
    logic [W-1:0]                cur_n_reg, cur_n_next;
    logic [IW-1:0]               top_reg, top_next;
    logic [IW-1:0]               i_reg, i_next;
    logic [W+1:0]                i2_reg, i2_next;
    logic [IW-1:0]               y_reg, y_next;
    logic [W+1:0]                y2_reg, y2_next;
    logic [W+1:0]                sum_reg, sum_next;
    logic [CW-1:0]               first_reg, first_next;
    logic                        second_reg, second_next;
    dlpc_pkg::res_t              result_reg, result_next;

    logic [H-1:0]  root;
    logic          sqrt_busy;
    logic [NW-1:0] inner_n;
    logic [W+2:0]  probe;
    logic [CW-1:0] count_now;
    logic [OW-1:0] count_ext;

    dlpc_isqrt #(
        .W (W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (cur_n_reg),
        .busy     (sqrt_busy),
        .root     (root)
    );

    always_comb
    begin
        inner_n   = n_wide_reg - (NW'(value_reg) << 1);
        probe     = (W+3)'(y2_reg) + (W+3)'(i2_reg);
        count_now = CW'(1) + (CW'(sum_reg) << 2);

        kind_next   = kind_reg;
        value_next  = value_reg;
        n_wide_next = n_wide_reg;
        cur_n_next  = cur_n_reg;
        top_next    = top_reg;
        i_next      = i_reg;
        i2_next     = i2_reg;
        y_next      = y_reg;
        y2_next     = y2_reg;
        sum_next    = sum_reg;
        first_next  = first_reg;
        second_next = second_reg;
        result_next = result_reg;
        count_ext   = '0;

        if (cmd.load)
        begin
            kind_next   = req.req_type;
            value_next  = req.value;
            second_next = 1'b0;
        end
        if (cmd.calc_n)
        begin
            n_wide_next = NW'(value_reg) * NW'(value_reg) + NW'(value_reg);
        end
        if (cmd.set_outer)
        begin
            cur_n_next = (kind_reg == dlpc_pkg::KIND_RAW) ? W'(value_reg) : n_wide_reg[W-1:0];
        end
        if (cmd.set_inner)
        begin
            cur_n_next  = inner_n[W-1:0];
            second_next = 1'b1;
        end
        if (cmd.walk_init)
        begin
            top_next = IW'(root);
            i_next   = '0;
            i2_next  = '0;
            y_next   = IW'(root);
            y2_next  = (W+2)'(root) * (W+2)'(root);
            sum_next = '0;
        end
        if (cmd.walk_step)
        begin
            if (probe > (W+3)'(cur_n_reg))
            begin
                // step y down: (y-1)^2 = y^2 - 2y + 1
                y_next  = y_reg - IW'(1);
                y2_next = y2_reg - ((W+2)'(y_reg) << 1) + (W+2)'(1);
            end
            else
            begin
                sum_next = sum_reg + (W+2)'(y_reg);
                i_next   = i_reg + IW'(1);
                i2_next  = i2_reg + ((W+2)'(i_reg) << 1) + (W+2)'(1);
            end
        end
        if (cmd.keep_first)
        begin
            first_next = count_now;
        end
        if (cmd.finish)
        begin
            count_ext = second_reg ? OW'(first_reg - count_now) : OW'(count_now);
            result_next.point_count = count_ext[dlpc_pkg::COUNT_W-1:0];
            result_next.status      = 1'b0;
        end
        if (cmd.fail)
        begin
            result_next.point_count = '0;
            result_next.status      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg <= 1'b0;
        end
        else
        begin
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        value_reg  <= value_next;
        n_wide_reg <= n_wide_next;
        cur_n_reg  <= cur_n_next;
        top_reg    <= top_next;
        i_reg      <= i_next;
        i2_reg     <= i2_next;
        y_reg      <= y_next;
        y2_reg     <= y2_next;
        sum_reg    <= sum_next;
        first_reg  <= first_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        stat.sqrt_busy  = sqrt_busy;
        stat.walk_done  = (i_reg > top_reg);
        stat.need_inner = (kind_reg == dlpc_pkg::KIND_RING) && !second_reg;
        case (kind_reg)
            dlpc_pkg::KIND_RAW:  stat.too_large = (NW'(value_reg) > BOUND_MAX);
            dlpc_pkg::KIND_DISK: stat.too_large = (n_wide_reg > BOUND_MAX);
            dlpc_pkg::KIND_RING: stat.too_large = (n_wide_reg > BOUND_MAX);
            default:             stat.too_large = 1'b1;
        endcase
    end

    assign result = result_reg;

endmodule

`default_nettype wire

FILE: sv/dlpc_ctrl.sv
// Controller state machine: sequences bound check, square root, walk and result.
// Depends on dlpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dlpc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire dlpc_pkg::dp_stat_t stat,
    output dlpc_pkg::ctrl_cmd_t     cmd,
    output logic                    busy,
    output logic                    done
);

    dlpc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dlpc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            dlpc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = dlpc_pkg::ST_PREP;
                end
            end
            dlpc_pkg::ST_PREP:
            begin
                cmd.calc_n = 1'b1;
                state_next = dlpc_pkg::ST_CHECK;
            end
            dlpc_pkg::ST_CHECK:
            begin
                if (stat.too_large)
                begin
                    cmd.fail   = 1'b1;
                    state_next = dlpc_pkg::ST_DONE;
                end
                else
                begin
                    cmd.set_outer = 1'b1;
                    state_next    = dlpc_pkg::ST_SQ_START;
                end
            end
            dlpc_pkg::ST_SQ_START:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = dlpc_pkg::ST_SQRT;
            end
            dlpc_pkg::ST_SQRT:
            begin
                if (!stat.sqrt_busy)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = dlpc_pkg::ST_WALK;
                end
            end
            dlpc_pkg::ST_WALK:
            begin
                if (!stat.walk_done)
                begin
                    cmd.walk_step = 1'b1;
                end
                else if (stat.need_inner)
                begin
                    // hold the outer disk, then count the inner one
                    cmd.keep_first = 1'b1;
                    cmd.set_inner  = 1'b1;
                    state_next     = dlpc_pkg::ST_SQ_START;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = dlpc_pkg::ST_DONE;
                end
            end
            dlpc_pkg::ST_DONE:
            begin
                state_next = dlpc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dlpc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != dlpc_pkg::ST_IDLE);
    assign done = (state_reg == dlpc_pkg::ST_DONE);

endmodule

`default_nettype wire

FILE: sv/disk_lattice_point_counter_core.sv
// Disk lattice point counter: one request at a time, one result strobe per request.
// Each count runs the square root unit, then the i/y walk, one step a cycle; a ring runs two
// counts. Out-of-range requests go from the bound check straight to the done state. busy
// stays high until the done cycle ends.
// Reset (rst_n, asynchronous, active low) returns the controller to idle; result
// data is not reset. The result is shown for one cycle and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module disk_lattice_point_counter_core #(
    parameter int BOUND_BITS = 24
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire dlpc_pkg::req_t req,
    output logic                busy,
    output logic                done,
    output dlpc_pkg::res_t      result
);

    dlpc_pkg::ctrl_cmd_t cmd;
    dlpc_pkg::dp_stat_t  stat;

    dlpc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    dlpc_datapath #(
        .BOUND_BITS (BOUND_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

`default_nettype wire

FILE: sv/dlpc_checker.sv
// Port-level checks on the lattice point counter's transaction sequencing.
// Depends on dlpc_pkg; bound to disk_lattice_point_counter_core.
`timescale 1ns / 1ps
`default_nettype none

module dlpc_props (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           done,
    input wire dlpc_pkg::res_t result
);

    // a result only appears while a transaction is in flight
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done without busy");

    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status) |-> (result.point_count == '0))
        else $error("failed transaction with non-zero count");

    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> $past(done))
        else $error("busy dropped without a result");

endmodule

bind disk_lattice_point_counter_core dlpc_props u_dlpc_props (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
